// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define CHK_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// ante at one edge implies cons at the next
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gbs_pkg.sv =====
// Shared types and constants of the greedy box suppression block
package gbs_pkg;

    localparam int CLASS_W   = 8;
    localparam int SCORE_W   = 16;
    localparam int SC_W      = SCORE_W + CLASS_W;
    localparam int THR_W     = 16;
    localparam int FRAC_BITS = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic store;
        logic last;
        logic ovf;
    } cmd_ctl_t;

endpackage

// ===== src/gbs_queue.sv =====
// Two-entry command queue between intake and engine
module gbs_queue #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output logic [DW-1:0] head_data
);

    logic [DW-1:0] mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign head_data = mem_reg[rd_ptr_reg];

endmodule

// ===== src/gbs_front.sv =====
// Intake: accepts boxes, counts them, classifies store, drop and frame close
module gbs_front import gbs_pkg::*; #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12,
    parameter int CW         = 7,
    parameter int IW         = 6,
    parameter int DW         = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CLASS_W-1:0]    class_id,
    input  logic [SCORE_W-1:0]    score,
    input  logic [COORD_BITS-1:0] left_x,
    input  logic [COORD_BITS-1:0] top_y,
    input  logic [COORD_BITS-1:0] right_x,
    input  logic [COORD_BITS-1:0] bottom_y,
    input  logic                  last_box,
    input  logic                  q_full,
    input  logic                  frame_done,
    output logic                  push,
    output logic [DW-1:0]         push_data
);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          ovf_reg;
    logic          closing_reg;
    logic          accept;
    cmd_ctl_t      ctl;

    assign busy          = q_full | closing_reg;
    assign accept        = start & ~busy;
    assign ctl.store     = (count_reg < CW'(MAX_BOXES));
    assign ctl.last      = last_box;
    assign ctl.ovf       = ovf_reg | ~ctl.store;
    assign count_next    = count_reg + CW'(ctl.store);
    assign push          = accept & (ctl.store | last_box);
    assign push_data     = {ctl, count_reg[IW-1:0], count_next, score, class_id,
                            left_x, top_y, right_x, bottom_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            closing_reg <= 1'b0;
        end
        else
        begin
            if (frame_done)
                closing_reg <= 1'b0;
            if (accept)
            begin
                if (last_box)
                begin
                    count_reg   <= '0;
                    ovf_reg     <= 1'b0;
                    closing_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_next;
                    ovf_reg   <= ctl.ovf;
                end
            end
        end
    end

endmodule

// ===== src/gbs_back.sv =====
// Engine: stores boxes, ranks by score, walks the greedy suppression
module gbs_back import gbs_pkg::*; #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12,
    parameter int CW         = 7,
    parameter int IW         = 6,
    parameter int DW         = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [THR_W-1:0]      thr,
    input  logic                  q_empty,
    input  logic [DW-1:0]         q_data,
    output logic                  q_pop,
    output logic                  frame_done,
    output logic                  result_valid,
    output logic [CLASS_W-1:0]    kept_class,
    output logic [SCORE_W-1:0]    kept_score,
    output logic [COORD_BITS-1:0] kept_left,
    output logic [COORD_BITS-1:0] kept_top,
    output logic [COORD_BITS-1:0] kept_right,
    output logic [COORD_BITS-1:0] kept_bottom,
    output logic                  final_result,
    output logic                  overflow
);

    localparam int CB  = COORD_BITS;
    localparam int BW  = 4 * CB;
    localparam int AW  = 2 * CB;
    localparam int UW  = AW + 1;
    localparam int PW  = UW + THR_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INS, ST_RANKW, ST_ORD, ST_OUTER, ST_OA, ST_OC, ST_OM,
        ST_INNER, ST_FLUSH
    } state_t;

    function automatic logic [CB-1:0] extent(input logic [CB-1:0] lo,
                                             input logic [CB-1:0] hi);
        extent = (hi > lo) ? (hi - lo) : '0;
    endfunction

    function automatic logic [CB-1:0] max_c(input logic [CB-1:0] a, input logic [CB-1:0] b);
        max_c = (a > b) ? a : b;
    endfunction

    function automatic logic [CB-1:0] min_c(input logic [CB-1:0] a, input logic [CB-1:0] b);
        min_c = (a < b) ? a : b;
    endfunction

    cmd_ctl_t         head_ctl;
    logic [IW-1:0]    head_slot;
    logic [CW-1:0]    head_cnt;
    logic [SC_W-1:0]  head_sc;
    logic [BW-1:0]    head_box;

    logic [BW-1:0]    corner_mem [MAX_BOXES];
    logic [SC_W-1:0]  sc_mem     [MAX_BOXES];
    logic [IW-1:0]    rank_mem   [MAX_BOXES];
    logic [IW-1:0]    order_mem  [MAX_BOXES];
    logic [BW-1:0]    corner_q;
    logic [SC_W-1:0]  sc_q;
    logic [IW-1:0]    rank_q;
    logic [IW-1:0]    order_q;

    state_t           state_reg;
    logic [CW-1:0]    j_reg;
    logic [CW-1:0]    i_reg;
    logic [IW-1:0]    idx_reg;
    logic [CW-1:0]    n_reg;
    logic             last_reg;
    logic             ovf_reg;
    logic [SCORE_W-1:0] s_reg;
    logic [IW-1:0]    cnt_reg;
    logic             v1_reg;
    logic [IW-1:0]    j1_reg;
    logic [BW-1:0]    ca_reg;
    logic [SC_W-1:0]  asc_reg;
    logic [CB-1:0]    wa_reg;
    logic [CB-1:0]    ha_reg;
    logic [AW-1:0]    area_a_reg;
    logic             pend_valid_reg;
    logic [SC_W-1:0]  pend_sc_reg;
    logic [BW-1:0]    pend_box_reg;
    logic             out_valid_reg;
    logic             out_final_reg;
    logic             out_ovf_reg;
    logic [SC_W-1:0]  out_sc_reg;
    logic [BW-1:0]    out_box_reg;
    logic [MAX_BOXES-1:0] supp_reg;

    logic             pv1_reg, pv2_reg, pv3_reg, pv4_reg, pv5_reg, pv6_reg;
    logic [IW-1:0]    b2_reg, b3_reg, b4_reg, b5_reg, b6_reg;
    logic [CB-1:0]    iw3_reg, ih3_reg, wb3_reg, hb3_reg;
    logic [AW-1:0]    inter4_reg, areab4_reg, inter5_reg;
    logic [UW-1:0]    uni5_reg;
    logic [PW-1:0]    lhs6_reg, rhs6_reg;

    logic             issue_ins, issue_ord, issue_inn, lower;
    logic             rank_we, order_we, box_we;
    logic [IW-1:0]    rank_wa, rank_wd, order_wa;
    logic [IW-1:0]    order_ra, sc_ra;
    logic             pipe_busy;

    assign {head_ctl, head_slot, head_cnt, head_sc, head_box} = q_data;

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign box_we    = q_pop && head_ctl.store;
    assign issue_ins = (state_reg == ST_INS) && (j_reg < CW'(idx_reg));
    assign issue_ord = (state_reg == ST_ORD) && (j_reg < n_reg);
    assign issue_inn = (state_reg == ST_INNER) && (j_reg < n_reg);
    assign lower     = sc_q[SC_W-1:CLASS_W] < s_reg;
    assign pipe_busy = pv1_reg | pv2_reg | pv3_reg | pv4_reg | pv5_reg | pv6_reg;
    assign order_ra  = (state_reg == ST_INNER) ? j_reg[IW-1:0] : i_reg[IW-1:0];
    assign sc_ra     = (state_reg == ST_INS) ? j_reg[IW-1:0] : order_q;
    assign frame_done = (state_reg == ST_FLUSH);

    always_comb
    begin
        rank_we  = 1'b0;
        rank_wa  = j1_reg;
        rank_wd  = rank_q + IW'(1);
        order_we = (state_reg == ST_ORD) && v1_reg;
        order_wa = rank_q;
        if ((state_reg == ST_INS) && v1_reg && lower)
            rank_we = 1'b1;
        else if (state_reg == ST_RANKW)
        begin
            rank_we = 1'b1;
            rank_wa = idx_reg;
            rank_wd = cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (box_we)
        begin
            corner_mem[head_slot] <= head_box;
            sc_mem[head_slot]     <= head_sc;
        end
        corner_q <= corner_mem[order_q];
        sc_q     <= sc_mem[sc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
            rank_mem[rank_wa] <= rank_wd;
        rank_q <= rank_mem[j_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (order_we)
            order_mem[order_wa] <= j1_reg;
        order_q <= order_mem[order_ra];
    end

    // pair test pipeline: box under test against the current survivor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv1_reg <= 1'b0;
            pv2_reg <= 1'b0;
            pv3_reg <= 1'b0;
            pv4_reg <= 1'b0;
            pv5_reg <= 1'b0;
            pv6_reg <= 1'b0;
        end
        else
        begin
            pv1_reg <= issue_inn;
            pv2_reg <= pv1_reg;
            pv3_reg <= pv2_reg;
            pv4_reg <= pv3_reg;
            pv5_reg <= pv4_reg;
            pv6_reg <= pv5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b2_reg     <= order_q;
        b3_reg     <= b2_reg;
        b4_reg     <= b3_reg;
        b5_reg     <= b4_reg;
        b6_reg     <= b5_reg;
        iw3_reg    <= extent(max_c(ca_reg[4*CB-1:3*CB], corner_q[4*CB-1:3*CB]),
                             min_c(ca_reg[2*CB-1:CB], corner_q[2*CB-1:CB]));
        ih3_reg    <= extent(max_c(ca_reg[3*CB-1:2*CB], corner_q[3*CB-1:2*CB]),
                             min_c(ca_reg[CB-1:0], corner_q[CB-1:0]));
        wb3_reg    <= extent(corner_q[4*CB-1:3*CB], corner_q[2*CB-1:CB]);
        hb3_reg    <= extent(corner_q[3*CB-1:2*CB], corner_q[CB-1:0]);
        inter4_reg <= AW'(iw3_reg) * AW'(ih3_reg);
        areab4_reg <= AW'(wb3_reg) * AW'(hb3_reg);
        uni5_reg   <= UW'(area_a_reg) + UW'(areab4_reg) - UW'(inter4_reg);
        inter5_reg <= inter4_reg;
        lhs6_reg   <= PW'({inter5_reg, FRAC_BITS'(0)});
        rhs6_reg   <= PW'(thr) * PW'(uni5_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            supp_reg <= '0;
        else if (state_reg == ST_FLUSH)
            supp_reg <= '0;
        else if (pv6_reg && (lhs6_reg > rhs6_reg))
            supp_reg[b6_reg] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            j_reg          <= '0;
            i_reg          <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            last_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
            s_reg          <= '0;
            cnt_reg        <= '0;
            v1_reg         <= 1'b0;
            j1_reg         <= '0;
            ca_reg         <= '0;
            asc_reg        <= '0;
            wa_reg         <= '0;
            ha_reg         <= '0;
            area_a_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_sc_reg    <= '0;
            pend_box_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_final_reg  <= 1'b0;
            out_ovf_reg    <= 1'b0;
            out_sc_reg     <= '0;
            out_box_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= 1'b0;
            out_final_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        idx_reg  <= head_slot;
                        n_reg    <= head_cnt;
                        last_reg <= head_ctl.last;
                        ovf_reg  <= head_ctl.ovf;
                        s_reg    <= head_sc[SC_W-1:CLASS_W];
                        j_reg    <= '0;
                        cnt_reg  <= '0;
                        v1_reg   <= 1'b0;
                        state_reg <= head_ctl.store ? ST_INS : ST_ORD;
                    end
                end
                ST_INS:
                begin
                    v1_reg <= issue_ins;
                    j1_reg <= j_reg[IW-1:0];
                    if (issue_ins)
                        j_reg <= j_reg + CW'(1);
                    if (v1_reg && !lower)
                        cnt_reg <= cnt_reg + IW'(1);
                    if (!issue_ins && !v1_reg)
                        state_reg <= ST_RANKW;
                end
                ST_RANKW:
                begin
                    j_reg  <= '0;
                    v1_reg <= 1'b0;
                    state_reg <= last_reg ? ST_ORD : ST_IDLE;
                end
                ST_ORD:
                begin
                    v1_reg <= issue_ord;
                    j1_reg <= j_reg[IW-1:0];
                    if (issue_ord)
                        j_reg <= j_reg + CW'(1);
                    if (!issue_ord && !v1_reg)
                    begin
                        i_reg          <= '0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_OUTER;
                    end
                end
                ST_OUTER:
                begin
                    state_reg <= (i_reg == n_reg) ? ST_FLUSH : ST_OA;
                end
                ST_OA:
                begin
                    if (supp_reg[order_q])
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= ST_OUTER;
                    end
                    else
                        state_reg <= ST_OC;
                end
                ST_OC:
                begin
                    ca_reg    <= corner_q;
                    asc_reg   <= sc_q;
                    wa_reg    <= extent(corner_q[4*CB-1:3*CB], corner_q[2*CB-1:CB]);
                    ha_reg    <= extent(corner_q[3*CB-1:2*CB], corner_q[CB-1:0]);
                    state_reg <= ST_OM;
                end
                ST_OM:
                begin
                    area_a_reg <= AW'(wa_reg) * AW'(ha_reg);
                    if (pend_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ovf_reg   <= ovf_reg;
                        out_sc_reg    <= pend_sc_reg;
                        out_box_reg   <= pend_box_reg;
                    end
                    pend_valid_reg <= 1'b1;
                    pend_sc_reg    <= asc_reg;
                    pend_box_reg   <= ca_reg;
                    j_reg          <= i_reg + CW'(1);
                    state_reg      <= ST_INNER;
                end
                ST_INNER:
                begin
                    if (issue_inn)
                        j_reg <= j_reg + CW'(1);
                    else if (!pipe_busy)
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= ST_OUTER;
                    end
                end
                ST_FLUSH:
                begin
                    out_valid_reg  <= pend_valid_reg;
                    out_final_reg  <= pend_valid_reg;
                    out_ovf_reg    <= ovf_reg;
                    out_sc_reg     <= pend_sc_reg;
                    out_box_reg    <= pend_box_reg;
                    pend_valid_reg <= 1'b0;
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign final_result = out_final_reg;
    assign overflow     = out_ovf_reg;
    assign kept_class   = out_sc_reg[CLASS_W-1:0];
    assign kept_score   = out_sc_reg[SC_W-1:CLASS_W];
    assign kept_left    = out_box_reg[4*CB-1:3*CB];
    assign kept_top     = out_box_reg[3*CB-1:2*CB];
    assign kept_right   = out_box_reg[2*CB-1:CB];
    assign kept_bottom  = out_box_reg[CB-1:0];

endmodule

// ===== src/greedy_box_suppression_top.sv =====
// Top level of the greedy box suppression block
//
//  channel   handshake               beat
//  box in    start / busy            class_id score left_x top_y right_x bottom_y last_box
//  config    cfg_valid / cfg_ready   cfg_data (overlap threshold, Q0.16)
//  result    result_valid (strobe)   kept_* final_result overflow
//
// A stored box's rank is found by one scan over the score and rank memories of the
// boxes stored before it, one entry a cycle.
// Closing a frame builds the order, then for each survivor the pair test pipeline
// takes one pair a cycle against the boxes ranked below it.
// No clearing pass after reset. The result strobe cannot be held off.
module greedy_box_suppression_top import gbs_pkg::*; #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CLASS_W-1:0]    class_id,
    input  logic [SCORE_W-1:0]    score,
    input  logic [COORD_BITS-1:0] left_x,
    input  logic [COORD_BITS-1:0] top_y,
    input  logic [COORD_BITS-1:0] right_x,
    input  logic [COORD_BITS-1:0] bottom_y,
    input  logic                  last_box,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [THR_W-1:0]      cfg_data,
    output logic                  result_valid,
    output logic [CLASS_W-1:0]    kept_class,
    output logic [SCORE_W-1:0]    kept_score,
    output logic [COORD_BITS-1:0] kept_left,
    output logic [COORD_BITS-1:0] kept_top,
    output logic [COORD_BITS-1:0] kept_right,
    output logic [COORD_BITS-1:0] kept_bottom,
    output logic                  final_result,
    output logic                  overflow
);

    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int IW = $clog2(MAX_BOXES);
    localparam int DW = $bits(cmd_ctl_t) + IW + CW + SC_W + 4 * COORD_BITS;

    logic [THR_W-1:0] thr_reg;
    logic             q_push, q_pop, q_full, q_empty, frame_done;
    logic [DW-1:0]    q_push_data, q_head_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid && cfg_ready)
            thr_reg <= cfg_data;
    end

    gbs_front #(
        .MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS), .CW(CW), .IW(IW), .DW(DW)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .class_id(class_id), .score(score), .left_x(left_x), .top_y(top_y),
        .right_x(right_x), .bottom_y(bottom_y), .last_box(last_box),
        .q_full(q_full), .frame_done(frame_done),
        .push(q_push), .push_data(q_push_data)
    );

    gbs_queue #(.DW(DW)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_push_data),
        .pop(q_pop), .full(q_full), .empty(q_empty), .head_data(q_head_data)
    );

    gbs_back #(
        .MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS), .CW(CW), .IW(IW), .DW(DW)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .thr(thr_reg),
        .q_empty(q_empty), .q_data(q_head_data), .q_pop(q_pop),
        .frame_done(frame_done),
        .result_valid(result_valid), .kept_class(kept_class), .kept_score(kept_score),
        .kept_left(kept_left), .kept_top(kept_top), .kept_right(kept_right),
        .kept_bottom(kept_bottom), .final_result(final_result), .overflow(overflow)
    );

endmodule

// ===== src/gbs_checker.sv =====
// Port-level checker for the greedy box suppression block, with its bind
`include "assert_macros.svh"

module gbs_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_box,
    input logic result_valid,
    input logic final_result
);

    `CHK_ALWAYS(a_final_with_strobe, clk, rst_n, !final_result || result_valid, "final flag without result")
    `CHK_NEXT(a_close_goes_busy, clk, rst_n, start && !busy && last_box, busy, "not busy after frame close")
    `CHK_NEXT(a_final_ends_frame, clk, rst_n, result_valid && final_result, !result_valid, "result after final")
    `CHK_NEXT(a_more_to_come, clk, rst_n, result_valid && !final_result, busy, "idle before final result")

endmodule

bind greedy_box_suppression_top gbs_checker u_gbs_checker (.*);
